[hdl/pcfr_pkg.sv]
`default_nettype none
package pcfr_pkg;

  localparam int SlotsDefault = 16;
  localparam int PageBitsDefault = 32;
  localparam int SlotW = 4;
  localparam int CountW = 5;
  localparam int OpW = 3;

  localparam logic [OpW-1:0] OpRead = 3'd0;
  localparam logic [OpW-1:0] OpWrite = 3'd1;
  localparam logic [OpW-1:0] OpReadNa = 3'd2;
  localparam logic [OpW-1:0] OpReturn = 3'd3;
  localparam logic [OpW-1:0] OpFlush = 3'd4;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic [31:0]    page;
  } pcfr_req_t;

  typedef struct packed {
    logic              hit;
    logic [SlotW-1:0]  slot;
    logic              fill_needed;
    logic              bypass_read;
    logic              writeback_valid;
    logic [31:0]       writeback_page;
    logic [CountW-1:0] dirty_count;
    logic              is_last;
  } pcfr_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the request
    logic lookup;    // register the tag match
    logic apply;     // perform the state update and build the result
    logic scan;      // clear the scan minimum for a flush step
    logic scan_step; // compare one slot in the flush scan
    logic flush_out; // emit the flushed page found by the scan
    logic flush_none;
  } pcfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_flush;
    logic scan_done;
    logic found;
    logic last_dirty; // exactly one dirty page is left
  } pcfr_stat_t;

endpackage
`default_nettype wire

[hdl/pcfr_datapath.sv]
`default_nettype none
module pcfr_datapath #(
  parameter int SLOTS = pcfr_pkg::SlotsDefault,
  parameter int PAGE_BITS = pcfr_pkg::PageBitsDefault
) (
  input  wire                 clk,
  input  wire                 rst,
  input  pcfr_pkg::pcfr_req_t req,
  input  pcfr_pkg::pcfr_cmd_t cmd,
  output pcfr_pkg::pcfr_stat_t stat,
  output pcfr_pkg::pcfr_rsp_t rsp
);
  import pcfr_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NW = $clog2(SLOTS + 1);
  localparam logic [NW-1:0] FullCount = NW'(SLOTS);

  logic [PAGE_BITS-1:0] slot_page [SLOTS];
  logic [SLOTS-1:0]     slot_valid;
  logic [SLOTS-1:0]     slot_dirty;
  logic [IW-1:0]        free_queue [SLOTS];
  logic [IW-1:0]        free_head;
  logic [NW-1:0]        free_count;
  logic [IW-1:0]        replace_ptr;

  logic [OpW-1:0]       op;
  logic [PAGE_BITS-1:0] page;
  logic                 match_any;
  logic [IW-1:0]        match_idx;

  // Flush scan state: one slot is examined per cycle.
  logic [IW-1:0]        scan_idx;
  logic                 scan_found;
  logic [IW-1:0]        best_idx;
  logic [PAGE_BITS-1:0] best_page;
  logic [NW-1:0]        dirty_cnt;

  logic [SLOTS-1:0]     hits;
  logic [IW-1:0]        hit_idx;
  logic [NW:0]          tail_sum;
  logic [IW-1:0]        tail;
  logic [IW-1:0]        alloc_slot;
  logic [IW-1:0]        head_inc;
  logic [IW-1:0]        ptr_inc;
  logic                 victim_dirty;
  logic [NW-1:0]        dirty_next;
  pcfr_rsp_t            rsp_next;

  // Tag compare against every slot and priority encode the lowest hit.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hits[i] = slot_valid[i] && (slot_page[i] == page);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hits[i]) begin
        hit_idx = IW'(i);
      end
    end
  end

  // Free list tail, allocation choice and pointer wrap at the slot count.
  always_comb begin
    tail_sum = (NW + 1)'(free_head) + (NW + 1)'(free_count);
    tail = (tail_sum >= (NW + 1)'(SLOTS)) ? IW'(tail_sum - (NW + 1)'(SLOTS))
                                          : IW'(tail_sum);
    alloc_slot = (free_count != '0) ? free_queue[free_head] : replace_ptr;
    head_inc = (32'(free_head) == SLOTS - 1) ? '0 : free_head + 1'b1;
    ptr_inc = (32'(replace_ptr) == SLOTS - 1) ? '0 : replace_ptr + 1'b1;
    victim_dirty = (free_count == '0) && slot_valid[alloc_slot]
                   && slot_dirty[alloc_slot];
  end

  // Result and dirty count for the current command.
  always_comb begin
    dirty_next = dirty_cnt;
    rsp_next = '0;
    rsp_next.is_last = 1'b1;
    if (cmd.flush_out) begin
      dirty_next = dirty_cnt - 1'b1;
      rsp_next.slot = 4'(best_idx);
      rsp_next.writeback_valid = 1'b1;
      rsp_next.writeback_page = 32'(best_page);
      rsp_next.is_last = (dirty_cnt == NW'(1));
    end else if (cmd.apply) begin
      unique case (op) inside
        OpRead, OpWrite: begin
          if (match_any) begin
            rsp_next.hit = 1'b1;
            rsp_next.slot = 4'(match_idx);
            if (op == OpWrite && !slot_dirty[match_idx]) begin
              dirty_next = dirty_cnt + 1'b1;
            end
          end else begin
            rsp_next.slot = 4'(alloc_slot);
            rsp_next.fill_needed = (op == OpRead);
            if (victim_dirty) begin
              rsp_next.writeback_valid = 1'b1;
              rsp_next.writeback_page = 32'(slot_page[alloc_slot]);
            end
            // Dirty count: victim dirty bit removed, new bit added.
            dirty_next = dirty_cnt - NW'(victim_dirty) + NW'(op == OpWrite);
          end
        end
        OpReadNa: begin
          rsp_next.hit = match_any;
          rsp_next.slot = match_any ? 4'(match_idx) : 4'd0;
          rsp_next.bypass_read = !match_any;
        end
        OpReturn: begin
          if (match_any) begin
            rsp_next.hit = 1'b1;
            rsp_next.slot = 4'(match_idx);
            if (slot_dirty[match_idx]) begin
              dirty_next = dirty_cnt - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    rsp_next.dirty_count = 5'(dirty_next);
  end

  assign stat.is_flush   = (op == OpFlush);
  assign stat.scan_done  = (32'(scan_idx) == SLOTS - 1);
  assign stat.found      = scan_found;
  assign stat.last_dirty = (dirty_cnt == NW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_dirty <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        free_queue[i] <= IW'(i);
      end
      free_head <= '0;
      free_count <= FullCount;
      replace_ptr <= '0;
      dirty_cnt <= '0;
      scan_idx <= '0;
      scan_found <= 1'b0;
    end else begin
      if (cmd.load) begin
        op <= req.op;
        page <= PAGE_BITS'(req.page);
      end
      if (cmd.lookup) begin
        match_any <= |hits;
        match_idx <= hit_idx;
      end
      if (cmd.apply || cmd.flush_out || cmd.flush_none) begin
        rsp <= rsp_next;
      end
      if (cmd.apply || cmd.flush_out) begin
        dirty_cnt <= dirty_next;
      end
      if (cmd.apply) begin
        unique case (op) inside
          OpRead, OpWrite: begin
            if (match_any) begin
              if (op == OpWrite) begin
                slot_dirty[match_idx] <= 1'b1;
              end
            end else begin
              slot_valid[alloc_slot] <= 1'b1;
              slot_page[alloc_slot] <= page;
              slot_dirty[alloc_slot] <= (op == OpWrite);
              if (free_count != '0) begin
                free_head <= head_inc;
                free_count <= free_count - 1'b1;
              end else begin
                replace_ptr <= ptr_inc;
              end
            end
          end
          OpReturn: begin
            if (match_any) begin
              slot_valid[match_idx] <= 1'b0;
              slot_dirty[match_idx] <= 1'b0;
              if (free_count != FullCount) begin
                free_queue[tail] <= match_idx;
                free_count <= free_count + 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.scan) begin
        scan_idx <= '0;
        scan_found <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (slot_valid[scan_idx] && slot_dirty[scan_idx]
            && (!scan_found || slot_page[scan_idx] < best_page)) begin
          scan_found <= 1'b1;
          best_idx <= scan_idx;
          best_page <= slot_page[scan_idx];
        end
        if (!stat.scan_done) begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      if (cmd.flush_out) begin
        slot_dirty[best_idx] <= 1'b0;
      end
    end
  end

  // The dirty counter never exceeds the slot count.
  a_dirty_range: assert property (@(posedge clk) disable iff (rst)
    dirty_cnt <= FullCount) else $error("dirty count out of range");
  // The free count never exceeds the slot count.
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    free_count <= FullCount) else $error("free count out of range");
  // A flushed slot is clean afterwards.
  a_flush_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.flush_out |=> !slot_dirty[$past(best_idx)])
    else $error("flushed slot still dirty");

endmodule
`default_nettype wire

[hdl/pcfr_ctrl.sv]
`default_nettype none
module pcfr_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  input  pcfr_pkg::pcfr_stat_t stat,
  output pcfr_pkg::pcfr_cmd_t  cmd
);
  import pcfr_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StLookup, StApply, StScan, StFlushOut, StOut
  } state_t;

  state_t state;
  logic   more;  // flush continues after the current result

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    unique case (state)
      StLookup: begin
        cmd.lookup = !stat.is_flush;
        cmd.scan = stat.is_flush;
      end
      StApply: cmd.apply = 1'b1;
      StScan: cmd.scan_step = 1'b1;
      StFlushOut: begin
        cmd.flush_out = stat.found;
        cmd.flush_none = !stat.found && !more;
      end
      default: begin
      end
    endcase
    if (state == StOut && out_ready && more) begin
      cmd.scan = 1'b1;
    end
  end

  assign in_ready = (state == StIdle);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      out_valid <= 1'b0;
      more <= 1'b0;
    end else begin
      unique case (state)
        StIdle: if (in_valid) state <= StLookup;
        StLookup: begin
          more <= 1'b0;
          state <= stat.is_flush ? StScan : StApply;
        end
        StApply: begin
          out_valid <= 1'b1;
          state <= StOut;
        end
        StScan: if (stat.scan_done) state <= StFlushOut;
        StFlushOut: begin
          out_valid <= 1'b1;
          // The page that clears the last dirty bit ends the flush.
          more <= stat.found && !stat.last_dirty;
          state <= StOut;
        end
        StOut: if (out_ready) begin
          out_valid <= 1'b0;
          state <= more ? StScan : StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

  // A pending result holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  // No request is taken while a result is pending.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("request taken while busy");
  // A taken request leads to a lookup.
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == StLookup) else $error("no lookup");

endmodule
`default_nettype wire

[hdl/page_cache_fifo_replace_unit.sv]
// Page cache tag and replacement controller.
// Requests arrive on in_valid/in_ready with payload in (op, page); results
// leave on out_valid/out_ready with payload out. One request is in work at a
// time. A read, write, read-no-allocate, return or unknown request shows its
// one result after a lookup step and an update into the result register,
// and the block is ready again the cycle after that result is taken.
// A flush scans all slots, one per cycle, to find the smallest dirty page.
// Its first result shows once the scan is over, and each further page comes
// from a new scan that starts when the previous result is taken; a flush with no
// dirty page gives one zero result with is_last set.
// A stalled receiver holds the result in the output register and the block
// waits; nothing is lost. Reset empties the cache and refills the free list
// with all slots in order.
`default_nettype none
module page_cache_fifo_replace_unit #(
  parameter int SLOTS = pcfr_pkg::SlotsDefault,
  parameter int PAGE_BITS = pcfr_pkg::PageBitsDefault
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  pcfr_pkg::pcfr_req_t in,
  output logic                out_valid,
  input  wire                 out_ready,
  output pcfr_pkg::pcfr_rsp_t out
);
  import pcfr_pkg::*;

  pcfr_cmd_t  cmd;
  pcfr_stat_t stat;

  pcfr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  pcfr_datapath #(.SLOTS(SLOTS), .PAGE_BITS(PAGE_BITS)) u_dp (
    .clk(clk), .rst(rst), .req(in), .cmd(cmd), .stat(stat), .rsp(out)
  );

endmodule
`default_nettype wire
